// ===== design/pwm_input_duty_meter_top_defines.svh =====
// ----------------------------------------------------------------------------
// PWM duty meter assertion macros
// Shared concurrent assertion templates for the duty meter design.
// ----------------------------------------------------------------------------
`ifndef PWM_INPUT_DUTY_METER_TOP_DEFINES_SVH
`define PWM_INPUT_DUTY_METER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PWMDM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwm duty meter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PWMDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwm duty meter: next-cycle check failed");

`endif

// ===== design/pwmdm_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM duty meter package
// Types and fixed constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package pwmdm_pkg;

  localparam logic [7:0] FULL_SCALE       = 8'd200;
  localparam logic [7:0] FAIL_LIMIT_RESET = 8'd5;
  localparam logic [7:0] STREAK_MAX       = 8'd255;
  localparam int         RATIO_BITS       = 8;
  localparam int         DIV_STEPS        = RATIO_BITS;
  localparam int         OUT_DATA_BITS    = 32;

  localparam logic CFG_INVERT_OUTPUT = 1'b0;
  localparam logic CFG_FAIL_LIMIT    = 1'b1;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    PH_FIRST_RISE = 2'd0,
    PH_FALL       = 2'd1,
    PH_NEXT_RISE  = 2'd2
  } edge_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOAD   = 2'd1,
    ST_DIVIDE = 2'd2,
    ST_FINISH = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic take_edge;
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

endpackage

// ===== design/pwmdm_ctrl.sv =====
// ----------------------------------------------------------------------------
// PWM duty meter controller
// Sequences edge captures and duty reads, and owns the handshake flags.
// ----------------------------------------------------------------------------
module pwmdm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  output pwmdm_pkg::dp_cmd_t cmd
);

  localparam int CNT_W = $clog2(pwmdm_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(pwmdm_pkg::DIV_STEPS - 1);

  pwmdm_pkg::ctrl_state_t state;
  pwmdm_pkg::ctrl_state_t state_next;
  logic [CNT_W-1:0]       step_count;
  logic [CNT_W-1:0]       step_count_next;
  logic                   m_tvalid_next;
  logic                   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pwmdm_pkg::ST_IDLE;
      step_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      step_count <= step_count_next;
      m_tvalid   <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next      = state;
    step_count_next = step_count;
    s_tready        = 1'b0;
    cmd             = '0;
    accept          = 1'b0;
    m_tvalid_next   = m_tvalid && !m_tready;
    case (state)
      pwmdm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        accept   = s_tvalid;
        if (accept && s_tuser == pwmdm_pkg::CMD_READ) begin
          state_next = pwmdm_pkg::ST_LOAD;
        end else if (accept) begin
          cmd.take_edge = 1'b1;
        end
      end
      pwmdm_pkg::ST_LOAD: begin
        cmd.load        = 1'b1;
        step_count_next = '0;
        state_next      = pwmdm_pkg::ST_DIVIDE;
      end
      pwmdm_pkg::ST_DIVIDE: begin
        cmd.step        = 1'b1;
        step_count_next = step_count + 1'b1;
        if (step_count == LAST_STEP) begin
          state_next = pwmdm_pkg::ST_FINISH;
        end
      end
      pwmdm_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          cmd.finish    = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = pwmdm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pwmdm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/pwmdm_datapath.sv =====
// ----------------------------------------------------------------------------
// PWM duty meter datapath
// Edge sequencer, restoring divider for the duty ratio, loss detection and
// the result register.
// ----------------------------------------------------------------------------
module pwmdm_datapath #(
  parameter int TIMER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  pwmdm_pkg::dp_cmd_t cmd,
  input  logic [15:0]        capture_time,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  output logic [7:0]         duty_ratio,
  output logic               signal_lost,
  output logic [15:0]        period_ticks
);

  localparam int PROD_W = TIMER_BITS + pwmdm_pkg::RATIO_BITS;

  logic                      invert_output;
  logic [7:0]                fail_limit;
  pwmdm_pkg::edge_phase_t    edge_phase;
  logic [TIMER_BITS-1:0]     rise_reference;
  logic [TIMER_BITS-1:0]     fall_stamp;
  logic [TIMER_BITS-1:0]     period_count;
  logic [TIMER_BITS-1:0]     high_count;
  logic [7:0]                zero_streak;
  logic [7:0]                held_ratio;

  logic [TIMER_BITS-1:0]     rem;
  logic [7:0]                low_bits;
  logic [7:0]                quot;
  logic                      period_zero;
  logic                      saturate;

  logic [TIMER_BITS+15:0]    time_ext;
  logic [TIMER_BITS-1:0]     stamp;
  logic [TIMER_BITS+15:0]    period_ext;
  logic [PROD_W-1:0]         product;
  logic [TIMER_BITS:0]       shifted;
  logic                      fits;
  logic [7:0]                ratio;
  logic [7:0]                limit;
  logic [7:0]                streak_next;
  logic [7:0]                held_next;
  logic                      lost_next;

  assign time_ext   = {{TIMER_BITS{1'b0}}, capture_time};
  assign stamp      = time_ext[TIMER_BITS-1:0];
  assign period_ext = {16'd0, period_count};
  assign product    = {8'd0, high_count} * PROD_W'(pwmdm_pkg::FULL_SCALE);
  assign shifted    = {rem, low_bits[7]};
  assign fits       = shifted >= {1'b0, period_count};

  always_comb begin
    limit = (fail_limit == 8'd0) ? 8'd1 : fail_limit;
    if (period_zero) begin
      ratio = 8'd0;
    end else if (saturate) begin
      ratio = pwmdm_pkg::FULL_SCALE;
    end else begin
      ratio = quot;
    end
    if (ratio == 8'd0) begin
      streak_next = (zero_streak < pwmdm_pkg::STREAK_MAX) ? zero_streak + 8'd1 : zero_streak;
      held_next   = (streak_next >= limit) ? 8'd0 : held_ratio;
    end else begin
      streak_next = 8'd0;
      held_next   = ratio;
    end
    lost_next = streak_next >= limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_output  <= 1'b0;
      fail_limit     <= pwmdm_pkg::FAIL_LIMIT_RESET;
      edge_phase     <= pwmdm_pkg::PH_FIRST_RISE;
      rise_reference <= '0;
      fall_stamp     <= '0;
      period_count   <= '0;
      high_count     <= '0;
      zero_streak    <= '0;
      held_ratio     <= '0;
    end else begin
      if (cfg_we && cfg_index == pwmdm_pkg::CFG_INVERT_OUTPUT) begin
        invert_output <= cfg_data[0];
      end
      if (cfg_we && cfg_index == pwmdm_pkg::CFG_FAIL_LIMIT) begin
        fail_limit <= cfg_data;
      end
      if (cmd.take_edge) begin
        case (edge_phase)
          pwmdm_pkg::PH_FIRST_RISE: begin
            rise_reference <= stamp;
            edge_phase     <= pwmdm_pkg::PH_FALL;
          end
          pwmdm_pkg::PH_FALL: begin
            fall_stamp <= stamp;
            edge_phase <= pwmdm_pkg::PH_NEXT_RISE;
          end
          pwmdm_pkg::PH_NEXT_RISE: begin
            period_count   <= stamp - rise_reference;
            high_count     <= fall_stamp - rise_reference;
            rise_reference <= stamp;
            edge_phase     <= pwmdm_pkg::PH_FALL;
          end
          default: begin
            edge_phase <= pwmdm_pkg::PH_FIRST_RISE;
          end
        endcase
      end
      if (cmd.finish) begin
        zero_streak <= streak_next;
        held_ratio  <= held_next;
        if (ratio != 8'd0) begin
          high_count <= '0;
        end
      end
    end
  end

  // Restoring division: the quotient is below 256 whenever high < period.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem         <= product[PROD_W-1:8];
      low_bits    <= product[7:0];
      quot        <= '0;
      period_zero <= period_count == '0;
      saturate    <= high_count >= period_count;
    end else if (cmd.step) begin
      rem      <= fits ? TIMER_BITS'(shifted - {1'b0, period_count}) : shifted[TIMER_BITS-1:0];
      low_bits <= {low_bits[6:0], 1'b0};
      quot     <= {quot[6:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      duty_ratio   <= invert_output ? pwmdm_pkg::FULL_SCALE - held_next : held_next;
      signal_lost  <= lost_next;
      period_ticks <= period_ext[15:0];
    end
  end

endmodule

// ===== design/pwm_input_duty_meter_top.sv =====
// ----------------------------------------------------------------------------
// PWM input duty meter
// Edge timestamps step a period and high-time sequencer; reads report the
// duty ratio in half-percent units with loss detection.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one word per event: s_tuser selects an edge
// capture (0) or a duty read (1), s_tdata carries the captured timer value.
// An edge word gives no output word. A read word gives one output word:
// a load state forms 200 times the high time, a restoring divider then
// finds one quotient bit per cycle, and a finish state updates the loss
// counter and the result once the output register is free.
// The input is not ready while a read is in work, so a new read is taken
// only after the last one is finished; edges run at one per cycle otherwise.
// The result sits in an output register; a stalled receiver holds it while
// the next item is taken, and only a second finished read waits for it.
// Configuration (invert_output, fail_limit) is written through cfg_we with
// no wait. A synchronous reset clears the edge and loss state and
// invert_output, sets fail_limit to 5 and drops m_tvalid; the result is kept.
// ----------------------------------------------------------------------------
`include "pwm_input_duty_meter_top_defines.svh"

module pwm_input_duty_meter_top #(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] capture_time
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] duty_ratio, [8] signal_lost, [24:9] period_ticks
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  pwmdm_pkg::dp_cmd_t cmd;
  logic [7:0]         duty_ratio;
  logic               signal_lost;
  logic [15:0]        period_ticks;

  pwmdm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  pwmdm_datapath #(
    .TIMER_BITS (TIMER_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .capture_time (s_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .duty_ratio   (duty_ratio),
    .signal_lost  (signal_lost),
    .period_ticks (period_ticks)
  );

  assign m_tdata = {7'd0, period_ticks, signal_lost, duty_ratio};

  `PWMDM_ASSERT_NOW(a_duty_in_range, m_tvalid, m_tdata[7:0] <= pwmdm_pkg::FULL_SCALE)
  `PWMDM_ASSERT_NOW(a_lost_forces_zero, m_tvalid && m_tdata[8], m_tdata[7:0] == 8'd0 || m_tdata[7:0] == pwmdm_pkg::FULL_SCALE)
  `PWMDM_ASSERT_NEXT(a_read_blocks_input, s_tvalid && s_tready && s_tuser, !s_tready)

endmodule

// ===== tb/sv/tb_pwm_input_duty_meter_top.sv =====
// ----------------------------------------------------------------------------
// PWM input duty meter testbench
// Sends edge and read words into the duty meter and checks every output word
// against a cycle-free predictor of the edge sequencer, the duty ratio and the
// loss counter. Directed tests cover the timer extremes, saturation, a zero
// period and loss detection; configuration tests cover inversion and the fail
// limit extremes; random tests send well-formed PWM periods with noise under
// several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_pwm_input_duty_meter_top;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic [7:0]  duty;
    logic        lost;
    logic [15:0] period;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = pwmdm_pkg::CMD_EDGE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = pwmdm_pkg::CFG_INVERT_OUTPUT;
  logic [7:0]  cfg_data = '0;

  reading_t    pending_readings[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          words_sent = 0;

  pwmdm_pkg::edge_phase_t phase_now;
  logic [15:0] rise_ref;
  logic [15:0] fall_time;
  logic [15:0] period_cnt;
  logic [15:0] high_cnt;
  logic [7:0]  zero_streak;
  logic [7:0]  held_ratio;
  logic        invert_on;
  logic [7:0]  fail_limit;

  pwm_input_duty_meter_top uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("** pwm_input_duty_meter_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: output word with none expected, actual %h", $time, m_tdata);
      end else begin
        want = pending_readings.pop_front();
        if (m_tdata[7:0] !== want.duty) begin
          errors++;
          $display("%0t: duty_ratio expected %0d actual %0d", $time, want.duty,
                   m_tdata[7:0]);
        end
        if (m_tdata[8] !== want.lost) begin
          errors++;
          $display("%0t: signal_lost expected %0d actual %0d", $time, want.lost,
                   m_tdata[8]);
        end
        if (m_tdata[24:9] !== want.period) begin
          errors++;
          $display("%0t: period_ticks expected %0d actual %0d", $time, want.period,
                   m_tdata[24:9]);
        end
      end
    end
  end

  function automatic logic [7:0] duty_of(logic [15:0] high, logic [15:0] period);
    logic [31:0] q;
    if (period == 16'd0) return 8'd0;
    q = (32'd200 * high) / period;
    return (q > pwmdm_pkg::FULL_SCALE) ? pwmdm_pkg::FULL_SCALE : q[7:0];
  endfunction

  task automatic meter_reset();
    phase_now = pwmdm_pkg::PH_FIRST_RISE;
    rise_ref = '0;
    fall_time = '0;
    period_cnt = '0;
    high_cnt = '0;
    zero_streak = '0;
    held_ratio = '0;
    invert_on = 1'b0;
    fail_limit = pwmdm_pkg::FAIL_LIMIT_RESET;
  endtask

  task automatic meter_edge(logic [15:0] stamp);
    case (phase_now)
      pwmdm_pkg::PH_FIRST_RISE: begin
        rise_ref = stamp;
        phase_now = pwmdm_pkg::PH_FALL;
      end
      pwmdm_pkg::PH_FALL: begin
        fall_time = stamp;
        phase_now = pwmdm_pkg::PH_NEXT_RISE;
      end
      pwmdm_pkg::PH_NEXT_RISE: begin
        period_cnt = stamp - rise_ref;
        high_cnt = fall_time - rise_ref;
        rise_ref = stamp;
        phase_now = pwmdm_pkg::PH_FALL;
      end
      default: phase_now = pwmdm_pkg::PH_FIRST_RISE;
    endcase
  endtask

  task automatic meter_read();
    logic [7:0] lim;
    logic [7:0] ratio;
    reading_t   r;
    lim = (fail_limit == 8'd0) ? 8'd1 : fail_limit;
    ratio = duty_of(high_cnt, period_cnt);
    if (ratio == 8'd0) begin
      if (zero_streak != pwmdm_pkg::STREAK_MAX) zero_streak++;
      if (zero_streak >= lim) held_ratio = 8'd0;
    end else begin
      zero_streak = 8'd0;
      held_ratio = ratio;
      high_cnt = 16'd0;
    end
    r.duty = invert_on ? pwmdm_pkg::FULL_SCALE - held_ratio : held_ratio;
    r.lost = (zero_streak >= lim);
    r.period = period_cnt;
    pending_readings.push_back(r);
  endtask

  task automatic send_word(logic cmd, logic [15:0] stamp);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      s_tvalid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= stamp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == pwmdm_pkg::CMD_READ) meter_read();
    else meter_edge(stamp);
    words_sent++;
  endtask

  task automatic push_edge(logic [15:0] stamp);
    send_word(pwmdm_pkg::CMD_EDGE, stamp);
  endtask

  task automatic push_read();
    send_word(pwmdm_pkg::CMD_READ, 16'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back; the block must be idle.
  task automatic set_config(logic invert, logic [7:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= pwmdm_pkg::CFG_INVERT_OUTPUT;
    cfg_data <= {7'($urandom), invert};
    @(posedge clk);
    invert_on = invert;
    cfg_index <= pwmdm_pkg::CFG_FAIL_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    fail_limit = limit;
    cfg_we <= 1'b0;
  endtask

  // One PWM cycle relative to the current rising-edge reference.
  task automatic push_cycle(logic [15:0] high, logic [15:0] period);
    logic [15:0] base;
    if (phase_now == pwmdm_pkg::PH_FIRST_RISE) push_edge(16'($urandom));
    base = rise_ref;
    if (phase_now == pwmdm_pkg::PH_FALL) push_edge(base + high);
    push_edge(base + period);
  endtask

  task automatic test_directed();
    push_read();
    push_edge(16'hFFFF);
    push_edge(16'h0063);
    push_edge(16'h00C7);
    push_read();
    push_read();
    push_cycle(16'd300, 16'd200);
    push_read();
    push_cycle(16'd0, 16'd0);
    push_read();
    push_cycle(16'hFFFF, 16'hFFFF);
    push_read();
    push_cycle(16'd1, 16'hFFFF);
    repeat (6) push_read();
    drain();
  endtask

  task automatic test_config();
    set_config(1'b1, 8'd0);
    push_cycle(16'd50, 16'd100);
    push_read();
    push_read();
    push_read();
    drain();
    set_config(1'b0, 8'd255);
    push_cycle(16'd0, 16'd1000);
    repeat (8) push_read();
    push_cycle(16'd999, 16'd1000);
    push_read();
    drain();
    set_config(1'b1, 8'd1);
    push_cycle(16'd1, 16'd2);
    push_read();
    push_read();
    drain();
  endtask

  task automatic test_random(int items);
    int          start;
    int          sel;
    logic [15:0] p;
    logic [15:0] h;
    start = words_sent;
    while (words_sent - start < items) begin
      sel = $urandom_range(99);
      if (sel < 80) begin
        case ($urandom_range(9))
          0: begin
            p = 16'd0;
            h = 16'($urandom);
          end
          1: begin
            p = 16'($urandom_range(1, 16));
            h = 16'($urandom_range(0, p));
          end
          2: begin
            p = 16'($urandom_range(1, 30000));
            h = p + 16'($urandom_range(1, 30000));
          end
          default: begin
            p = 16'($urandom_range(1, 65535));
            h = 16'($urandom_range(0, p));
          end
        endcase
        push_cycle(h, p);
        repeat ($urandom_range(1, 3)) push_read();
      end else if (sel < 90) begin
        repeat ($urandom_range(1, 2)) push_edge(16'($urandom));
      end else begin
        repeat ($urandom_range(2, 12)) push_read();
      end
    end
    drain();
  endtask

  initial begin
    meter_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config();
    set_config(1'b0, 8'd3);
    test_random(380);
    send_idle_pct = 51;
    set_config(1'b1, 8'd1);
    test_random(380);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    set_config(1'b0, 8'd255);
    test_random(380);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    set_config(1'b1, 8'd0);
    test_random(380);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** pwm_input_duty_meter_top: PASSED **");
    end else begin
      $display("** pwm_input_duty_meter_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/pwmdm_pkg.sv
design/pwmdm_ctrl.sv
design/pwmdm_datapath.sv
design/pwm_input_duty_meter_top.sv
tb/sv/tb_pwm_input_duty_meter_top.sv
